@@ hw/rtl/mpct_pkg.sv @@
// Shared types, constants and helper functions for the PS/2 mouse cursor tracker.
package mpct_pkg;

    localparam int BYTE_W = 8;
    localparam int DIM_W  = 13;
    localparam int POS_W  = 12;
    localparam int SUM_W  = POS_W + 2;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam int SYNC_BIT  = 3;
    localparam int XSIGN_BIT = 4;
    localparam int YSIGN_BIT = 5;
    localparam int LEFT_BIT  = 0;
    localparam int RIGHT_BIT = 1;

    localparam logic [DIM_W-1:0] RESET_WIDTH  = 13'd320;
    localparam logic [DIM_W-1:0] RESET_HEIGHT = 13'd200;
    localparam logic [DIM_W-1:0] DIM_MAX      = 13'd4096;
    localparam logic [POS_W-1:0] RESET_X      = 12'd160;
    localparam logic [POS_W-1:0] RESET_Y      = 12'd100;

    localparam logic [1:0] PHASE_HEADER = 2'd0;
    localparam logic [1:0] PHASE_XDELTA = 2'd1;
    localparam logic [1:0] PHASE_YDELTA = 2'd2;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [POS_W-1:0] x_max;
        logic [POS_W-1:0] y_max;
    } limits_t;

    function automatic logic [POS_W-1:0] dim_limit(input logic [DIM_W-1:0] dim);
        logic [DIM_W-1:0] dm1;
        dm1 = dim - 13'd1;
        if (dim == '0)
            return '0;
        else if (dim >= DIM_MAX)
            return {POS_W{1'b1}};
        else
            return dm1[POS_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] clamp_pos(input logic [SUM_W-1:0] sum,
                                                   input logic [POS_W-1:0] hi);
        if (sum[SUM_W-1])
            return '0;
        else if (sum[SUM_W-2:0] > {1'b0, hi})
            return hi;
        else
            return sum[POS_W-1:0];
    endfunction

endpackage

@@ hw/rtl/ps2_mouse_packet_cursor_tracker.sv @@
// Top level of the PS/2 mouse three-byte packet decoder with cursor tracking.
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------------------------
//   in      | in_valid/in_ready  | mouse_byte
//   out     | out_valid/out_ready| cursor_x, cursor_y, left_button, right_button
//   apb     | psel/penable/pready| paddr, pwrite, pwdata, prdata
//
// One byte per cycle unless a held result stalls; the third byte's result is registered.
// Throughput is set by the single decode stage between the byte and result registers.
// Reset puts the cursor at 160,100 on a 320x200 screen, awaiting a header byte.
// A held result stalls the input only when the next byte would produce another one.
module ps2_mouse_packet_cursor_tracker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mpct_pkg::ADDR_W-1:0]   paddr,
    input  logic [mpct_pkg::DATA_W-1:0]   pwdata,
    output logic [mpct_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [mpct_pkg::BYTE_W-1:0]   mouse_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mpct_pkg::POS_W-1:0]    cursor_x,
    output logic [mpct_pkg::POS_W-1:0]    cursor_y,
    output logic                          left_button,
    output logic                          right_button
);

    mpct_pkg::limits_t limits;

    mpct_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .limits  (limits)
    );

    mpct_packet u_packet
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .limits       (limits),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mouse_byte   (mouse_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .cursor_x     (cursor_x),
        .cursor_y     (cursor_y),
        .left_button  (left_button),
        .right_button (right_button)
    );

endmodule

@@ hw/rtl/mpct_apb_regs.sv @@
// APB register file holding the screen dimensions and deriving their clamp limits.
module mpct_apb_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mpct_pkg::ADDR_W-1:0]   paddr,
    input  logic [mpct_pkg::DATA_W-1:0]   pwdata,
    output logic [mpct_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output mpct_pkg::limits_t             limits
);

    logic [mpct_pkg::DIM_W-1:0] width_reg;
    logic [mpct_pkg::DIM_W-1:0] height_reg;
    logic                       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= mpct_pkg::RESET_WIDTH;
            height_reg <= mpct_pkg::RESET_HEIGHT;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                mpct_pkg::REG_WIDTH:  width_reg  <= pwdata[mpct_pkg::DIM_W-1:0];
                mpct_pkg::REG_HEIGHT: height_reg <= pwdata[mpct_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            mpct_pkg::REG_WIDTH:
                prdata = {{(mpct_pkg::DATA_W-mpct_pkg::DIM_W){1'b0}}, width_reg};
            mpct_pkg::REG_HEIGHT:
                prdata = {{(mpct_pkg::DATA_W-mpct_pkg::DIM_W){1'b0}}, height_reg};
            default:
                prdata = '0;
        endcase
    end

    assign limits.x_max = mpct_pkg::dim_limit(width_reg);
    assign limits.y_max = mpct_pkg::dim_limit(height_reg);

endmodule

@@ hw/rtl/mpct_packet.sv @@
// Byte input register, packet assembly, cursor update and result register.
module mpct_packet
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  mpct_pkg::limits_t             limits,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [mpct_pkg::BYTE_W-1:0]   mouse_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mpct_pkg::POS_W-1:0]    cursor_x,
    output logic [mpct_pkg::POS_W-1:0]    cursor_y,
    output logic                          left_button,
    output logic                          right_button
);

    logic                          byte_valid_reg;
    logic [mpct_pkg::BYTE_W-1:0]   byte_reg;
    logic [1:0]                    phase_reg;
    logic [1:0]                    phase_next;
    logic [mpct_pkg::BYTE_W-1:0]   header_reg;
    logic [mpct_pkg::BYTE_W-1:0]   header_next;
    logic [mpct_pkg::BYTE_W-1:0]   xdelta_reg;
    logic [mpct_pkg::BYTE_W-1:0]   xdelta_next;
    logic [mpct_pkg::POS_W-1:0]    pos_x_reg;
    logic [mpct_pkg::POS_W-1:0]    pos_x_next;
    logic [mpct_pkg::POS_W-1:0]    pos_y_reg;
    logic [mpct_pkg::POS_W-1:0]    pos_y_next;
    logic                          out_valid_reg;
    logic [mpct_pkg::POS_W-1:0]    cursor_x_reg;
    logic [mpct_pkg::POS_W-1:0]    cursor_y_reg;
    logic                          left_reg;
    logic                          right_reg;
    logic                          emit;
    logic                          advance;
    logic                          in_fire;
    logic [mpct_pkg::SUM_W-1:0]    sum_x;
    logic [mpct_pkg::SUM_W-1:0]    sum_y;

    assign emit    = byte_valid_reg && (phase_reg == mpct_pkg::PHASE_YDELTA);
    assign advance = byte_valid_reg && (!emit || !out_valid_reg || out_ready);
    assign in_ready = !byte_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    // hold the beat until the decode stage takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_valid_reg <= 1'b0;
        else if (in_ready)
            byte_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            byte_reg <= mouse_byte;
    end

    assign sum_x = {2'b00, pos_x_reg}
                 + {{(mpct_pkg::SUM_W-mpct_pkg::BYTE_W){header_reg[mpct_pkg::XSIGN_BIT]}},
                    xdelta_reg};
    assign sum_y = {2'b00, pos_y_reg}
                 - {{(mpct_pkg::SUM_W-mpct_pkg::BYTE_W){header_reg[mpct_pkg::YSIGN_BIT]}},
                    byte_reg};

    always_comb
    begin
        phase_next  = phase_reg;
        header_next = header_reg;
        xdelta_next = xdelta_reg;
        pos_x_next  = pos_x_reg;
        pos_y_next  = pos_y_reg;
        unique case (phase_reg)
            mpct_pkg::PHASE_XDELTA:
            begin
                xdelta_next = byte_reg;
                phase_next  = mpct_pkg::PHASE_YDELTA;
            end
            mpct_pkg::PHASE_YDELTA:
            begin
                phase_next = mpct_pkg::PHASE_HEADER;
                pos_x_next = mpct_pkg::clamp_pos(sum_x, limits.x_max);
                pos_y_next = mpct_pkg::clamp_pos(sum_y, limits.y_max);
            end
            default:
            begin
                // drop bytes without the sync bit to resynchronize
                if (byte_reg[mpct_pkg::SYNC_BIT])
                begin
                    header_next = byte_reg;
                    phase_next  = mpct_pkg::PHASE_XDELTA;
                end
                else
                begin
                    phase_next = mpct_pkg::PHASE_HEADER;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= mpct_pkg::PHASE_HEADER;
            header_reg <= '0;
            xdelta_reg <= '0;
            pos_x_reg  <= mpct_pkg::RESET_X;
            pos_y_reg  <= mpct_pkg::RESET_Y;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            header_reg <= header_next;
            xdelta_reg <= xdelta_next;
            pos_x_reg  <= pos_x_next;
            pos_y_reg  <= pos_y_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            cursor_x_reg <= pos_x_next;
            cursor_y_reg <= pos_y_next;
            left_reg     <= header_reg[mpct_pkg::LEFT_BIT];
            right_reg    <= header_reg[mpct_pkg::RIGHT_BIT];
        end
    end

    assign out_valid    = out_valid_reg;
    assign cursor_x     = cursor_x_reg;
    assign cursor_y     = cursor_y_reg;
    assign left_button  = left_reg;
    assign right_button = right_reg;

endmodule
